// ===== rtl/tcft_pkg.sv =====
// Package for the TCP connection tracking filter: field widths, codes and
// the TCP state transition function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcft_pkg;
    localparam int ENTRIES_DEF = 64;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [7:0] FL_FIN = 8'd1;
    localparam logic [7:0] FL_SYN = 8'd2;
    localparam logic [7:0] FL_RST = 8'd4;
    localparam logic [7:0] FL_ACK = 8'd16;

    localparam logic [3:0] ST_EST        = 4'd1;
    localparam logic [3:0] ST_SYN_SENT   = 4'd2;
    localparam logic [3:0] ST_SYN_RECV   = 4'd3;
    localparam logic [3:0] ST_FIN_WAIT1  = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT2  = 4'd5;
    localparam logic [3:0] ST_TIME_WAIT  = 4'd6;
    localparam logic [3:0] ST_CLOSE      = 4'd7;
    localparam logic [3:0] ST_CLOSE_WAIT = 4'd8;
    localparam logic [3:0] ST_LAST_ACK   = 4'd9;
    localparam logic [3:0] ST_CLOSING    = 4'd11;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_NO_ENTRY = 2'd2;
    localparam logic [1:0] STS_REJECT   = 2'd3;

    localparam logic [3:0] WSHIFT_RESET = 4'd10;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] srv_seq;
        logic [31:0] cli_seq;
        logic [3:0]  server_st;
        logic [3:0]  client_st;
        logic [31:0] srv_win;
        logic [31:0] cli_win;
    } entry_t;

    // Result of the flag-driven transition.
    typedef struct packed {
        logic       ok;
        logic       chal;
        logic [3:0] fs;
        logic [3:0] fr;
    } trans_t;

    function automatic trans_t tcp_transition(input logic [3:0] snd, input logic [3:0] rec,
                                              input logic [7:0] raw);
        trans_t t;
        logic [7:0] f;
        logic tail;
        t = '0;
        tail = 1'b0;
        f = raw & (FL_ACK | FL_FIN | FL_SYN | FL_RST);
        case (snd) inside
            ST_EST: begin
                if (f == FL_ACK) begin
                    t.ok = 1'b1; t.fs = ST_EST; t.fr = ST_EST;
                end else if (f == (FL_FIN | FL_ACK)) begin
                    t.ok = 1'b1; t.fs = ST_FIN_WAIT1; t.fr = ST_CLOSE_WAIT;
                end else if (f == (FL_ACK | FL_RST)) begin
                    t.ok = 1'b1; t.fs = ST_CLOSE; t.fr = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (f == FL_SYN) begin
                    t.ok = 1'b1; t.fs = ST_SYN_SENT; t.fr = ST_SYN_RECV;
                end
            end
            ST_SYN_RECV: begin
                if (f == (FL_SYN | FL_ACK)) begin
                    t.ok = 1'b1; t.fs = snd; t.fr = ST_EST;
                end else if (f == FL_SYN) begin
                    t.ok = 1'b1; t.fs = ST_SYN_RECV; t.fr = ST_SYN_RECV;
                end else if (f == (FL_FIN | FL_ACK)) begin
                    t.ok = 1'b1; t.fs = ST_FIN_WAIT1; t.fr = ST_CLOSE_WAIT;
                end else if (f == (FL_RST | FL_ACK)) begin
                    t.ok = 1'b1; t.fs = ST_CLOSE; t.fr = ST_CLOSE;
                end
            end
            ST_CLOSE_WAIT: begin
                if (f == FL_ACK) begin
                    t.ok = 1'b1; t.fs = ST_CLOSE_WAIT; t.fr = ST_FIN_WAIT2; t.chal = 1'b1;
                end else if (f == (FL_FIN | FL_ACK)) begin
                    t.ok = 1'b1;
                    if (rec == ST_FIN_WAIT1) begin
                        t.fs = ST_CLOSING; t.fr = ST_CLOSING;
                    end else begin
                        t.fs = ST_LAST_ACK; t.fr = ST_TIME_WAIT;
                    end
                end else if (f == (FL_ACK | FL_RST)) begin
                    t.ok = 1'b1; t.fs = ST_CLOSE; t.fr = ST_CLOSE;
                end
            end
            ST_FIN_WAIT1, ST_FIN_WAIT2: begin
                if (f == FL_ACK) begin
                    t.ok = 1'b1; t.fs = snd; t.fr = rec;
                end else begin
                    tail = 1'b1;
                end
            end
            ST_TIME_WAIT: begin
                if (f == FL_ACK) begin
                    t.ok = 1'b1; t.fs = ST_CLOSE; t.fr = ST_CLOSE;
                end else begin
                    tail = 1'b1;
                end
            end
            ST_CLOSING: tail = 1'b1;
            default: t.ok = 1'b0;
        endcase
        // Closing states fall back to CLOSE on a bare ACK, with or without RST.
        if (tail && ((raw & (FL_ACK | FL_FIN | FL_SYN)) == FL_ACK)) begin
            t.ok = 1'b1;
            t.fs = ST_CLOSE;
            t.fr = ((raw & FL_RST) != 8'd0) ? ST_CLOSE : rec;
        end
        return t;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tcft_search.sv =====
// Key search over the valid bits and a key memory, one entry per cycle.
// Depends on tcft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcft_search #(
    parameter int ENTRIES = tcft_pkg::ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [31:0]   key,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_idx,
    output logic               done,
    output logic               found,
    output logic [IW-1:0]      hit_idx,
    output logic               has_free,
    output logic [IW-1:0]      free_idx
);
    import tcft_pkg::*;

    logic [31:0]      key_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]      rd_key_reg;
    logic [IW:0]      cnt_reg;       // address issued
    logic             busy_reg;
    logic             rd_vld_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             found_reg, free_reg;
    logic [IW-1:0]    hit_reg, fidx_reg;
    logic [31:0]      key_reg;
    logic             done_reg;
    logic             last_cmp;

    // Key memory: the key latched at start is stored on a rule write,
    // and one address is read each cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) key_mem[wr_idx] <= key_reg;
        rd_key_reg <= key_mem[cnt_reg[IW-1:0]];
    end

    assign last_cmp = rd_vld_reg && (rd_idx_reg == IW'(ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            busy_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= busy_reg && last_cmp;
            if (wr_en) valid_reg[wr_idx] <= 1'b1;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                rd_vld_reg <= 1'b0;
                key_reg    <= key;
                found_reg  <= 1'b0;
                free_reg   <= 1'b0;
            end else if (busy_reg) begin
                rd_vld_reg <= (cnt_reg < (IW+1)'(ENTRIES));
                rd_idx_reg <= cnt_reg[IW-1:0];
                if (cnt_reg < (IW+1)'(ENTRIES)) cnt_reg <= cnt_reg + 1'b1;
                // Compare the entry read in the previous cycle.
                if (rd_vld_reg) begin
                    if (valid_reg[rd_idx_reg] && rd_key_reg == key_reg && !found_reg) begin
                        found_reg <= 1'b1;
                        hit_reg   <= rd_idx_reg;
                    end
                    if (!valid_reg[rd_idx_reg] && !free_reg) begin
                        free_reg <= 1'b1;
                        fidx_reg <= rd_idx_reg;
                    end
                end
                if (last_cmp) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign hit_idx  = hit_reg;
    assign has_free = free_reg;
    assign free_idx = fidx_reg;
endmodule
`default_nettype wire

// ===== rtl/tcp_connection_tracking_filter_core.sv =====
// Top level of the TCP connection tracking filter: stream ports, sequencer,
// entry memory and TCP update. Depends on tcft_pkg and tcft_search.
// A word passes the key scan, entry read, evaluation and output register in
// that order before m_tvalid. A new word is taken only once the previous
// verdict has gone into the output register, so the serial key search sets the pace;
// a held result is kept in the output register, and only a second finished
// word waits for it. Reset: synchronous active-low aresetn empties the table,
// sets window_shift to 10.
`timescale 1ns / 1ps
`default_nettype none
module tcp_connection_tracking_filter_core #(
    parameter int ENTRIES = tcft_pkg::ENTRIES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         s_tuser,   // kind
    // protocol, src_addr, dst_addr, src_port, dst_port, tcp_flags,
    // seq_num, ack_num, window (from bit 0 up)
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata    // allow, status, zero pad
);
    import tcft_pkg::*;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SRCH  = 5'b00010,
        S_READ  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t       state_reg;
    logic [3:0]   wshift_reg;
    logic         kind_reg;
    logic [7:0]   proto_reg, flags_reg;
    logic [31:0]  sa_reg, da_reg, seq_reg, ack_reg;
    logic [15:0]  sp_reg, dp_reg, win_reg;
    logic [31:0]  key_c;
    logic [31:0]  key_c_reg;
    logic         found_reg;
    logic         res_vld_reg;
    logic         allow_reg;
    logic [1:0]   status_reg;
    logic         out_allow_reg;
    logic [1:0]   out_status_reg;
    logic         out_load;
    logic         srch_start, srch_done, found, has_free;
    logic [IW-1:0] hit_idx, free_idx, idx_reg;
    logic         key_wr;
    entry_t       ent_mem [ENTRIES];
    entry_t       rd_ent_reg, wr_ent;
    logic         ent_we;

    assign key_c = s_tdata[39:8] ^ {16'd0, s_tdata[87:72]} ^ s_tdata[71:40]
                 ^ {16'd0, s_tdata[103:88]} ^ {24'd0, s_tdata[7:0]};

    assign s_tready   = aresetn && (state_reg == S_IDLE);
    assign srch_start = s_tvalid && s_tready;

    tcft_search #(.ENTRIES(ENTRIES)) u_search (
        .aclk(aclk), .aresetn(aresetn), .start(srch_start), .key(key_c),
        .wr_en(key_wr), .wr_idx(idx_reg), .done(srch_done), .found(found),
        .hit_idx(hit_idx), .has_free(has_free), .free_idx(free_idx)
    );

    // Entry memory, read through a register at the settled address.
    always_ff @(posedge aclk) begin
        if (ent_we) ent_mem[idx_reg] <= wr_ent;
        rd_ent_reg <= ent_mem[idx_reg];
    end

    // TCP evaluation on the read entry.
    logic        srv;
    logic [3:0]  snd, rec;
    trans_t      tr;
    logic [31:0] own_seq, own_win, peer_seq, chal_seq, win_sh, dlo, dhi, dack, dchal, dsrv;
    logic        reject_seq, chal_pass, syn;
    logic [3:0]  fs;
    entry_t      upd;
    always_comb begin
        srv      = sa_reg < da_reg;
        snd      = srv ? rd_ent_reg.server_st : rd_ent_reg.client_st;
        rec      = srv ? rd_ent_reg.client_st : rd_ent_reg.server_st;
        tr       = tcp_transition(snd, rec, flags_reg);
        own_seq  = srv ? rd_ent_reg.srv_seq : rd_ent_reg.cli_seq;
        own_win  = srv ? rd_ent_reg.srv_win : rd_ent_reg.cli_win;
        peer_seq = srv ? rd_ent_reg.cli_seq : rd_ent_reg.srv_seq;
        chal_seq = srv ? rd_ent_reg.cli_seq : rd_ent_reg.srv_seq;
        win_sh   = {16'd0, win_reg} << wshift_reg;
        syn      = (flags_reg & FL_SYN) != 8'd0;
        dlo      = seq_reg - own_seq;
        dhi      = seq_reg - (own_seq + own_win);
        dack     = ack_reg - peer_seq;
        dchal    = ack_reg - chal_seq;
        // Both sides test the sequence against the server sequence in the challenge.
        dsrv     = seq_reg - rd_ent_reg.srv_seq;
        reject_seq = (dlo[31] || !dhi[31]) && !syn;
        chal_pass  = dchal[31] && dsrv[31] && tr.chal;
        fs = tr.fs;
        if (tr.fs == ST_CLOSING && tr.fr == ST_CLOSING && dack != 32'd0 && !dack[31])
            fs = ST_CLOSE;
        upd = rd_ent_reg;
        if (srv) begin
            upd.cli_seq = ack_reg; upd.cli_win = win_sh;
            upd.server_st = fs;    upd.client_st = tr.fr;
        end else begin
            upd.srv_seq = ack_reg; upd.srv_win = win_sh;
            upd.client_st = fs;    upd.server_st = tr.fr;
        end
        if ((flags_reg & FL_RST) != 8'd0 || (fs == ST_CLOSE && tr.fr == ST_CLOSE)) begin
            upd.cli_seq = '0; upd.srv_seq = '0;
        end
    end

    // Write controls for the rule store and the TCP update.
    always_comb begin
        ent_we = 1'b0;
        key_wr = 1'b0;
        wr_ent = upd;
        if (state_reg == S_EXEC) begin
            if (!kind_reg) begin
                ent_we = status_reg == STS_OK;
                key_wr = status_reg == STS_OK;
                wr_ent = '{key: key_c_reg, srv_seq: '0, cli_seq: '0, server_st: ST_CLOSE,
                           client_st: ST_CLOSE, srv_win: '0, cli_win: '0};
            end else if (proto_reg == PROTO_TCP && found_reg) begin
                ent_we = tr.ok && !reject_seq && !chal_pass;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wshift_reg  <= WSHIFT_RESET;
        end else begin
            if (cfg_we) wshift_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE: begin
                    if (srch_start) begin
                        kind_reg  <= s_tuser;
                        proto_reg <= s_tdata[7:0];
                        sa_reg    <= s_tdata[39:8];
                        da_reg    <= s_tdata[71:40];
                        sp_reg    <= s_tdata[87:72];
                        dp_reg    <= s_tdata[103:88];
                        flags_reg <= s_tdata[111:104];
                        seq_reg   <= s_tdata[143:112];
                        ack_reg   <= s_tdata[175:144];
                        win_reg   <= s_tdata[191:176];
                        key_c_reg <= key_c;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (srch_done) begin
                        found_reg <= found;
                        idx_reg   <= found ? hit_idx : free_idx;
                        status_reg <= (!found && !has_free) ? STS_FULL : STS_OK;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC: begin
                    if (!kind_reg) begin
                        status_reg <= status_reg;
                        allow_reg  <= 1'b0;
                    end else if (proto_reg == PROTO_UDP) begin
                        status_reg <= found_reg ? STS_OK : STS_NO_ENTRY;
                        allow_reg  <= found_reg;
                    end else if (proto_reg == PROTO_TCP) begin
                        if (!found_reg) begin
                            status_reg <= STS_NO_ENTRY;
                            allow_reg  <= 1'b0;
                        end else if (!tr.ok || reject_seq) begin
                            status_reg <= STS_REJECT;
                            allow_reg  <= 1'b0;
                        end else begin
                            status_reg <= STS_OK;
                            allow_reg  <= 1'b1;
                        end
                    end else begin
                        status_reg <= STS_REJECT;
                        allow_reg  <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register: takes the verdict once the previous word has left.
    assign out_load = (state_reg == S_OUT) && (!res_vld_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (out_load) begin
            res_vld_reg    <= 1'b1;
            out_allow_reg  <= allow_reg;
            out_status_reg <= status_reg;
        end else if (m_tready) begin
            res_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_allow_reg};
endmodule
`default_nettype wire

// ===== rtl/tcft_checker.sv =====
// Port-level checker for the filter core, bound to the top level.
// Depends on tcp_connection_tracking_filter_core.
`timescale 1ns / 1ps
`default_nettype none
module tcft_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [7:0]   m_tdata
);
    // A result stalled by the consumer holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    // Allowed results always report ok.
    a_allow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == 2'd0)
        else $error("allow with bad status");
    // An accepted word blocks the input in the next cycle.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");
    // Pad bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("pad bits set");
endmodule

bind tcp_connection_tracking_filter_core tcft_checker u_tcft_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
